// ===== design/dffsh_pkg.sv =====
package dffsh_pkg;

  // heap geometry
  localparam int unsigned ADDR_W = 10;
  localparam int unsigned SLOTS  = 1 << ADDR_W;
  localparam int unsigned SIZE_W = ADDR_W + 1;
  localparam int unsigned DATA_W = 8;

  // slot marks
  localparam logic [1:0] MARK_FREE = 2'd0;
  localparam logic [1:0] MARK_HELD = 2'd1;
  localparam logic [1:0] MARK_RESV = 2'd2;

  // value of heap_start after reset
  localparam logic [ADDR_W-1:0] HEAP_START_RST = ADDR_W'(SLOTS - 1);

  typedef enum logic [1:0] {
    FUNC_RESERVE = 2'd0,
    FUNC_STORE   = 2'd1,
    FUNC_LOAD    = 2'd2
  } func_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN,
    ST_MARK,
    ST_ACC_RD,
    ST_ACC_WB,
    ST_RESULT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic clear_step;
    logic item_load;
    logic scan_init;
    logic scan_step;
    logic mark_step;
    logic acc_rd;
    logic acc_wb;
    logic out_load;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       clear_last;
    logic [1:0] func;
    logic       trivial_fail;
    logic       hit;
    logic       scan_fail;
    logic       mark_last;
    logic       out_free;
  } dp_status_t;

endpackage

// ===== design/dffsh_ctrl.sv =====
module dffsh_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  dffsh_pkg::dp_status_t status_i,
  output dffsh_pkg::ctrl_cmd_t  cmd_o
);
  import dffsh_pkg::*;

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (status_i.clear_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        unique case (status_i.func)
          FUNC_RESERVE: begin
            state_d = status_i.trivial_fail ? ST_RESULT : ST_SCAN;
          end
          FUNC_STORE, FUNC_LOAD: begin
            state_d = ST_ACC_RD;
          end
          default: begin
            state_d = ST_RESULT;
          end
        endcase
      end
      ST_SCAN: begin
        if (status_i.hit) begin
          state_d = ST_MARK;
        end else if (status_i.scan_fail) begin
          state_d = ST_RESULT;
        end
      end
      ST_MARK: begin
        if (status_i.mark_last) state_d = ST_RESULT;
      end
      ST_ACC_RD: begin
        state_d = ST_ACC_WB;
      end
      ST_ACC_WB: begin
        state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_step = 1'b1;
      end
      ST_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.item_load = in_valid_i;
      end
      ST_DISPATCH: begin
        cmd_o.scan_init = (status_i.func == FUNC_RESERVE) && !status_i.trivial_fail;
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
      end
      ST_MARK: begin
        cmd_o.mark_step = 1'b1;
      end
      ST_ACC_RD: begin
        cmd_o.acc_rd = 1'b1;
      end
      ST_ACC_WB: begin
        cmd_o.acc_wb = 1'b1;
      end
      ST_RESULT: begin
        cmd_o.out_load = status_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

// ===== design/dffsh_datapath.sv =====
module dffsh_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  dffsh_pkg::ctrl_cmd_t             cmd_i,
  output dffsh_pkg::dp_status_t            status_o,
  input  logic                             cfg_we_i,
  input  logic [dffsh_pkg::ADDR_W-1:0]     cfg_wdata_i,
  input  logic [1:0]                       func_i,
  input  logic [dffsh_pkg::SIZE_W-1:0]     size_i,
  input  logic [dffsh_pkg::ADDR_W-1:0]     stack_limit_i,
  input  logic [dffsh_pkg::ADDR_W-1:0]     address_i,
  input  logic [dffsh_pkg::DATA_W-1:0]     write_data_i,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic                             status_bit_o,
  output logic [dffsh_pkg::ADDR_W-1:0]     base_address_o,
  output logic [dffsh_pkg::DATA_W-1:0]     read_data_o
);
  import dffsh_pkg::*;

  // slot marks and byte store
  logic [1:0]        mark_mem [SLOTS];
  logic [DATA_W-1:0] byte_mem [SLOTS];

  logic [ADDR_W-1:0] heap_start_q, heap_bottom_q;
  logic [1:0]        func_q;
  logic [SIZE_W-1:0] size_q;
  logic [ADDR_W-1:0] limit_q, addr_q;
  logic [DATA_W-1:0] wdata_q;

  logic [ADDR_W-1:0] clr_cnt_q;
  logic              issuing_q, eval_valid_q;
  logic [ADDR_W-1:0] issue_addr_q, eval_addr_q;
  logic [SIZE_W-1:0] run_q;
  logic [ADDR_W-1:0] wptr_q;
  logic [SIZE_W-1:0] rem_q;

  logic [1:0]        mark_rd_q;
  logic [DATA_W-1:0] byte_rd_q;

  logic              res_status_q;
  logic [ADDR_W-1:0] res_base_q;
  logic [DATA_W-1:0] res_rdata_q;

  logic              out_valid_q;
  logic              out_status_q;
  logic [ADDR_W-1:0] out_base_q;
  logic [DATA_W-1:0] out_rdata_q;

  logic              mark_rd_en;
  logic [ADDR_W-1:0] mark_rd_addr;
  logic              mark_we;
  logic [ADDR_W-1:0] mark_wa;
  logic [1:0]        mark_wd;
  logic              byte_we;
  logic [SIZE_W-1:0] run_next;
  logic              eval_now, hit, in_heap, acc_ok, out_free, last_issue;

  // scan evaluation on the registered mark
  always_comb begin
    run_next   = (mark_rd_q == MARK_FREE) ? run_q + SIZE_W'(1) : '0;
    eval_now   = cmd_i.scan_step && eval_valid_q;
    hit        = eval_now && (eval_addr_q <= heap_start_q) && (run_next >= size_q);
    last_issue = issue_addr_q == limit_q + ADDR_W'(1);
  end

  // store and load checks
  always_comb begin
    in_heap = (addr_q <= heap_start_q) && (addr_q >= heap_bottom_q);
    acc_ok  = in_heap &&
              (((func_q == FUNC_STORE) && (mark_rd_q == MARK_RESV)) ||
               ((func_q == FUNC_LOAD)  && (mark_rd_q == MARK_HELD)));
    out_free = !out_valid_q || out_ready_i;
  end

  // mark memory port selection
  always_comb begin
    mark_rd_en   = (cmd_i.scan_step && issuing_q) || cmd_i.acc_rd;
    mark_rd_addr = cmd_i.acc_rd ? addr_q : issue_addr_q;
    mark_we      = 1'b0;
    mark_wa      = addr_q;
    mark_wd      = MARK_FREE;
    byte_we      = 1'b0;
    if (cmd_i.clear_step) begin
      mark_we = 1'b1;
      mark_wa = clr_cnt_q;
      mark_wd = MARK_FREE;
    end else if (cmd_i.mark_step) begin
      mark_we = 1'b1;
      mark_wa = wptr_q;
      mark_wd = MARK_RESV;
    end else if (cmd_i.acc_wb && acc_ok) begin
      mark_we = 1'b1;
      mark_wa = addr_q;
      mark_wd = (func_q == FUNC_STORE) ? MARK_HELD : MARK_FREE;
      byte_we = func_q == FUNC_STORE;
    end
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (mark_rd_en) mark_rd_q <= mark_mem[mark_rd_addr];
    if (mark_we) mark_mem[mark_wa] <= mark_wd;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_rd) byte_rd_q <= byte_mem[addr_q];
    if (byte_we) byte_mem[addr_q] <= wdata_q;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_start_q  <= HEAP_START_RST;
      heap_bottom_q <= HEAP_START_RST;
      clr_cnt_q     <= '0;
      issuing_q     <= 1'b0;
      eval_valid_q  <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        heap_start_q  <= cfg_wdata_i;
        heap_bottom_q <= cfg_wdata_i;
      end else if (hit && (eval_addr_q < heap_bottom_q)) begin
        heap_bottom_q <= eval_addr_q;
      end
      if (cmd_i.clear_step) clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
      if (cmd_i.scan_init) begin
        issuing_q    <= 1'b1;
        eval_valid_q <= 1'b0;
      end else if (cmd_i.scan_step) begin
        eval_valid_q <= issuing_q && !hit;
        if (hit || last_issue) issuing_q <= 1'b0;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.item_load) begin
      func_q       <= func_i;
      size_q       <= size_i;
      limit_q      <= stack_limit_i;
      addr_q       <= address_i;
      wdata_q      <= write_data_i;
      res_status_q <= 1'b1;
      res_base_q   <= '0;
      res_rdata_q  <= '0;
    end
    if (cmd_i.scan_init) begin
      issue_addr_q <= heap_bottom_q;
      run_q        <= '0;
    end
    if (cmd_i.scan_step) begin
      if (issuing_q) begin
        eval_addr_q  <= issue_addr_q;
        issue_addr_q <= issue_addr_q - ADDR_W'(1);
      end
      if (eval_valid_q) run_q <= run_next;
    end
    if (hit) begin
      res_status_q <= 1'b0;
      res_base_q   <= eval_addr_q;
      wptr_q       <= eval_addr_q;
      rem_q        <= size_q;
    end
    if (cmd_i.mark_step) begin
      wptr_q <= wptr_q + ADDR_W'(1);
      rem_q  <= rem_q - SIZE_W'(1);
    end
    if (cmd_i.acc_wb && acc_ok) begin
      res_status_q <= 1'b0;
      res_rdata_q  <= (func_q == FUNC_LOAD) ? byte_rd_q : '0;
    end
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_base_q   <= res_base_q;
      out_rdata_q  <= res_rdata_q;
    end
  end

  // status back to the controller
  always_comb begin
    status_o.clear_last   = clr_cnt_q == ADDR_W'(SLOTS - 1);
    status_o.func         = func_q;
    status_o.trivial_fail = (size_q == '0) || (heap_bottom_q <= limit_q);
    status_o.hit          = hit;
    status_o.scan_fail    = eval_now && !issuing_q && !hit;
    status_o.mark_last    = rem_q == SIZE_W'(1);
    status_o.out_free     = out_free;
  end

  assign out_valid_o    = out_valid_q;
  assign status_bit_o   = out_status_q;
  assign base_address_o = out_base_q;
  assign read_data_o    = out_rdata_q;

  // consistency checks
  a_bottom_below_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    heap_bottom_q <= heap_start_q)
    else $error("heap bottom above heap start");

  a_hit_below_bottom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit |-> eval_addr_q <= heap_bottom_q)
    else $error("reserve hit above heap bottom");

  a_mark_in_heap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mark_step |-> (wptr_q >= heap_bottom_q) && (rem_q != '0))
    else $error("reservation write outside heap");

  a_out_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> out_free)
    else $error("result overwrites an untaken beat");

endmodule

// ===== design/downward_first_fit_slot_heap_unit.sv =====
// store/load: an accepted beat passes through dispatch, mark read, update and result; func 3,
//   zero size or empty range: dispatch, then result
// reserve: dispatch, scan of the slots, then on a hit a mark write per reserved slot, then result; single mark port
// throughput: one item at a time; next beat taken once the result is registered
// reset: async active low; then the clear state frees all 1024 slot marks, no beat taken,
//   configuration writes still accepted
module downward_first_fit_slot_heap_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [dffsh_pkg::ADDR_W-1:0] cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   func_i,
  input  logic [dffsh_pkg::SIZE_W-1:0] size_i,
  input  logic [dffsh_pkg::ADDR_W-1:0] stack_limit_i,
  input  logic [dffsh_pkg::ADDR_W-1:0] address_i,
  input  logic [dffsh_pkg::DATA_W-1:0] write_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         status_o,
  output logic [dffsh_pkg::ADDR_W-1:0] base_address_o,
  output logic [dffsh_pkg::DATA_W-1:0] read_data_o
);
  import dffsh_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t dp_status;

  // sequencer
  dffsh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (dp_status),
    .cmd_o      (cmd)
  );

  // slot map, byte store and result registers
  dffsh_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (dp_status),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .func_i         (func_i),
    .size_i         (size_i),
    .stack_limit_i  (stack_limit_i),
    .address_i      (address_i),
    .write_data_i   (write_data_i),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .status_bit_o   (status_o),
    .base_address_o (base_address_o),
    .read_data_o    (read_data_o)
  );

endmodule

// ===== verif/slot_heap_checker.sv =====
`timescale 1ns / 100ps

module slot_heap_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [dffsh_pkg::ADDR_W-1:0] cfg_wdata_i,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic [1:0]                   func_i,
  input  logic [dffsh_pkg::SIZE_W-1:0] size_i,
  input  logic [dffsh_pkg::ADDR_W-1:0] stack_limit_i,
  input  logic [dffsh_pkg::ADDR_W-1:0] address_i,
  input  logic [dffsh_pkg::DATA_W-1:0] write_data_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic                         status_i,
  input  logic [dffsh_pkg::ADDR_W-1:0] base_address_i,
  input  logic [dffsh_pkg::DATA_W-1:0] read_data_i,
  output int unsigned                  fail_count_o,
  output int unsigned                  owed_o
);
  import dffsh_pkg::*;

  // one result beat
  typedef struct packed {
    logic              status;
    logic [ADDR_W-1:0] base;
    logic [DATA_W-1:0] rdata;
  } heap_result_t;

  // local copy of the heap
  logic [1:0]        mark_q [SLOTS];
  logic [DATA_W-1:0] byte_q [SLOTS];
  logic [ADDR_W-1:0] top_q;
  logic [ADDR_W-1:0] bottom_q;

  heap_result_t owed_results [$];
  heap_result_t want;
  int           slot_i;

  // print one line and count
  task automatic report_mismatch(input string msg);
    $display("%0t heap check: %s", $time, msg);
    fail_count_o++;
  endtask

  function automatic logic slot_in_range(input logic [ADDR_W-1:0] addr);
    return (addr <= top_q) && (addr >= bottom_q);
  endfunction

  // downward scan for the highest start of a free run at or below the bottom
  function automatic heap_result_t first_fit(input logic [SIZE_W-1:0] n,
                                             input logic [ADDR_W-1:0] lim);
    heap_result_t r;
    int unsigned  run;
    int           a;
    int           k;
    r.status = 1'b1;
    r.base   = '0;
    r.rdata  = '0;
    run      = 0;
    if (n == '0) return r;
    for (a = int'(bottom_q); a > int'(lim); a--) begin
      if (mark_q[a] == MARK_FREE) begin
        run++;
      end else begin
        run = 0;
      end
      if (a <= int'(top_q) && run >= int'(n)) begin
        for (k = 0; k < int'(n); k++) mark_q[a+k] = MARK_RESV;
        if (ADDR_W'(a) < bottom_q) bottom_q = ADDR_W'(a);
        r.status = 1'b0;
        r.base   = ADDR_W'(a);
        return r;
      end
    end
    return r;
  endfunction

  // result of one request, updating the local heap copy
  function automatic heap_result_t predict_heap_result(
    input logic [1:0]        f,
    input logic [SIZE_W-1:0] n,
    input logic [ADDR_W-1:0] lim,
    input logic [ADDR_W-1:0] addr,
    input logic [DATA_W-1:0] wd
  );
    heap_result_t r;
    r.status = 1'b1;
    r.base   = '0;
    r.rdata  = '0;
    case (f)
      FUNC_RESERVE: begin
        r = first_fit(n, lim);
      end
      FUNC_STORE: begin
        if (slot_in_range(addr) && mark_q[addr] == MARK_RESV) begin
          byte_q[addr] = wd;
          mark_q[addr] = MARK_HELD;
          r.status     = 1'b0;
        end
      end
      FUNC_LOAD: begin
        if (slot_in_range(addr) && mark_q[addr] == MARK_HELD) begin
          r.rdata      = byte_q[addr];
          mark_q[addr] = MARK_FREE;
          r.status     = 1'b0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // watch both channels and the register port
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (slot_i = 0; slot_i < int'(SLOTS); slot_i++) begin
        mark_q[slot_i] = MARK_FREE;
        byte_q[slot_i] = '0;
      end
      top_q    = HEAP_START_RST;
      bottom_q = HEAP_START_RST;
      owed_results.delete();
      fail_count_o = 0;
      owed_o       = 0;
    end else begin
      // result beat against the oldest prediction
      if (out_valid_i && out_ready_i) begin
        if (owed_results.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing owed (status %0d base %0d data %0d)",
                                    status_i, base_address_i, read_data_i));
        end else begin
          want = owed_results.pop_front();
          if (status_i !== want.status)
            report_mismatch($sformatf("status got %0d want %0d", status_i, want.status));
          if (base_address_i !== want.base)
            report_mismatch($sformatf("base_address got %0d want %0d",
                                      base_address_i, want.base));
          if (read_data_i !== want.rdata)
            report_mismatch($sformatf("read_data got %0d want %0d", read_data_i, want.rdata));
        end
      end
      // register write also reloads the bottom
      if (cfg_we_i) begin
        top_q    = cfg_wdata_i;
        bottom_q = cfg_wdata_i;
      end
      // request beat
      if (in_valid_i && in_ready_i) begin
        owed_results.push_back(predict_heap_result(func_i, size_i, stack_limit_i,
                                                   address_i, write_data_i));
      end
      owed_o = owed_results.size();
    end
  end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import dffsh_pkg::*;

  localparam logic [1:0]  FUNC_UNKNOWN = 2'd3;
  localparam int unsigned QUIET_LIMIT  = 20000;

  // what the sender handed over, kept to steer later requests
  typedef struct {
    logic [1:0]        func;
    logic [SIZE_W-1:0] n;
    logic [ADDR_W-1:0] addr;
  } sent_beat_t;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              cfg_we     = 1'b0;
  logic [ADDR_W-1:0] cfg_wdata  = '0;
  logic              in_valid   = 1'b0;
  logic              in_ready;
  logic [1:0]        heap_func  = '0;
  logic [SIZE_W-1:0] heap_size  = '0;
  logic [ADDR_W-1:0] heap_limit = '0;
  logic [ADDR_W-1:0] heap_addr  = '0;
  logic [DATA_W-1:0] heap_wdata = '0;
  logic              out_valid;
  logic              out_ready  = 1'b0;
  logic              status;
  logic [ADDR_W-1:0] base_address;
  logic [DATA_W-1:0] read_data;
  int unsigned       fail_count;
  int unsigned       owed;

  int unsigned       send_idle_pct  = 0;
  int unsigned       recv_stall_pct = 0;
  int unsigned       quiet_cycles   = 0;

  sent_beat_t        sent_q [$];
  sent_beat_t        seen;
  logic [ADDR_W-1:0] resv_pool [$];
  logic [ADDR_W-1:0] held_pool [$];
  int                grant_k;

  always #5 clk = ~clk;

  downward_first_fit_slot_heap_unit dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .func_i         (heap_func),
    .size_i         (heap_size),
    .stack_limit_i  (heap_limit),
    .address_i      (heap_addr),
    .write_data_i   (heap_wdata),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .status_o       (status),
    .base_address_o (base_address),
    .read_data_o    (read_data)
  );

  slot_heap_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .func_i         (heap_func),
    .size_i         (heap_size),
    .stack_limit_i  (heap_limit),
    .address_i      (heap_addr),
    .write_data_i   (heap_wdata),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .status_i       (status),
    .base_address_i (base_address),
    .read_data_i    (read_data),
    .fail_count_o   (fail_count),
    .owed_o         (owed)
  );

  // receiver back-pressure
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // granted and filled slots feed the store and load picks
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready && sent_q.size() != 0) begin
      seen = sent_q.pop_front();
      if (status == 1'b0) begin
        case (seen.func)
          FUNC_RESERVE: begin
            for (grant_k = 0; grant_k < int'(seen.n) && grant_k < 16; grant_k++) begin
              if (resv_pool.size() < 256) resv_pool.push_back(ADDR_W'(base_address + grant_k));
            end
          end
          FUNC_STORE: begin
            if (held_pool.size() < 256) held_pool.push_back(seen.addr);
          end
          default: ;
        endcase
      end
    end
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // one request beat; entered and left at a falling edge, valid left high
  task automatic send_item(input logic [1:0]        f,
                           input logic [SIZE_W-1:0] n,
                           input logic [ADDR_W-1:0] lim,
                           input logic [ADDR_W-1:0] addr,
                           input logic [DATA_W-1:0] wd);
    sent_beat_t s;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid   <= 1'b1;
    heap_func  <= f;
    heap_size  <= n;
    heap_limit <= lim;
    heap_addr  <= addr;
    heap_wdata <= wd;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    s.func = f;
    s.n    = n;
    s.addr = addr;
    sent_q.push_back(s);
    @(negedge clk);
  endtask

  // drop valid and hold off until every result is back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (owed != 0);
  endtask

  // mostly reserve, fill and drain sequences, with some noise
  task automatic send_random_item();
    logic [1:0]        f;
    logic [SIZE_W-1:0] n;
    logic [ADDR_W-1:0] lim;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] wd;
    int unsigned       pick;
    int unsigned       idx;
    f    = 2'($urandom);
    n    = SIZE_W'($urandom_range(SLOTS));
    lim  = ADDR_W'($urandom);
    addr = ADDR_W'($urandom);
    wd   = DATA_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 30) begin
      f = FUNC_RESERVE;
      case ($urandom_range(19))
        0:       n = '0;
        1:       n = SIZE_W'(SLOTS);
        2, 3:    n = SIZE_W'($urandom_range(64, 1));
        default: n = SIZE_W'($urandom_range(6, 1));
      endcase
      if ($urandom_range(3) != 0) lim = '0;
    end else if (pick < 60) begin
      f = FUNC_STORE;
      if (resv_pool.size() != 0 && $urandom_range(9) != 0) begin
        idx  = $urandom_range(resv_pool.size() - 1);
        addr = resv_pool[idx];
        resv_pool.delete(idx);
      end
    end else if (pick < 88) begin
      f = FUNC_LOAD;
      if (held_pool.size() != 0 && $urandom_range(9) != 0) begin
        idx  = $urandom_range(held_pool.size() - 1);
        addr = held_pool[idx];
        held_pool.delete(idx);
      end
    end else if (pick < 94) begin
      f = FUNC_UNKNOWN;
    end
    send_item(f, n, lim, addr, wd);
  endtask

  // new heap top written while idle, then a run of random requests
  task automatic run_phase(input logic [ADDR_W-1:0] top,
                           input int unsigned       send_pct,
                           input int unsigned       recv_pct,
                           input int unsigned       count);
    int unsigned i;
    wait_drained();
    cfg_we         <= 1'b1;
    cfg_wdata      <= top;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    @(negedge clk);
    cfg_we <= 1'b0;
    for (i = 0; i < count; i++) begin
      if ($urandom_range(99) < 2) wait_drained();
      send_random_item();
    end
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= HEAP_START_RST;
    @(negedge clk);
    cfg_we <= 1'b0;

    // directed: zero size, empty slots, unknown func, fill and drain, range walls
    send_item(FUNC_RESERVE, 11'd0,    10'd0,    10'd0,    8'd0);
    send_item(FUNC_LOAD,    11'd0,    10'd0,    10'd1023, 8'd0);
    send_item(FUNC_STORE,   11'd0,    10'd0,    10'd1023, 8'd255);
    send_item(FUNC_UNKNOWN, 11'd1024, 10'd1023, 10'd1023, 8'd255);
    send_item(FUNC_RESERVE, 11'd1,    10'd0,    10'd0,    8'd0);
    send_item(FUNC_STORE,   11'd0,    10'd0,    10'd1023, 8'd255);
    send_item(FUNC_STORE,   11'd0,    10'd0,    10'd1023, 8'd0);
    send_item(FUNC_LOAD,    11'd0,    10'd0,    10'd1023, 8'd0);
    send_item(FUNC_LOAD,    11'd0,    10'd0,    10'd1023, 8'd0);
    send_item(FUNC_RESERVE, 11'd4,    10'd0,    10'd0,    8'd0);
    send_item(FUNC_STORE,   11'd0,    10'd0,    10'd1020, 8'd0);
    send_item(FUNC_STORE,   11'd0,    10'd0,    10'd1023, 8'd165);
    send_item(FUNC_STORE,   11'd0,    10'd0,    10'd1000, 8'd90);
    send_item(FUNC_RESERVE, 11'd1024, 10'd0,    10'd0,    8'd0);
    send_item(FUNC_RESERVE, 11'd2,    10'd1018, 10'd0,    8'd0);
    send_item(FUNC_RESERVE, 11'd2,    10'd1017, 10'd0,    8'd0);
    send_item(FUNC_LOAD,    11'd0,    10'd0,    10'd1020, 8'd0);
    send_item(FUNC_LOAD,    11'd0,    10'd0,    10'd1023, 8'd0);
    send_item(FUNC_RESERVE, 11'd1,    10'd1023, 10'd0,    8'd0);
    send_item(FUNC_STORE,   11'd0,    10'd0,    10'd0,    8'd1);
    send_item(FUNC_LOAD,    11'd0,    10'd0,    10'd1021, 8'd0);
    send_item(FUNC_RESERVE, 11'd1,    10'd0,    10'd0,    8'd0);

    // random phases over several heap tops and idling mixes
    run_phase(10'd0,                                 0,  0,  40);
    run_phase(HEAP_START_RST,                        0,  0,  140);
    run_phase(ADDR_W'($urandom_range(1023, 300)),    46, 0,  140);
    run_phase(ADDR_W'($urandom_range(60, 8)),        0,  46, 100);
    run_phase(HEAP_START_RST,                        18, 18, 140);
    run_phase(ADDR_W'($urandom),                     0,  0,  140);

    wait_drained();
    repeat (40) @(negedge clk);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
